FILE: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and controller/datapath signal groups for the
// sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int MAX_ENTRIES   = 512;
  localparam int MAX_KEY_CHARS = 8;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CHR_W  = $clog2(MAX_KEY_CHARS);
  localparam int CI_W   = $clog2(MAX_KEY_CHARS + 1);
  localparam int LEN_W  = 4;
  localparam int CHAR_W = 16;

  localparam logic [CHAR_W-1:0] FOLD_LOW   = 16'h0041;
  localparam logic [CHAR_W-1:0] FOLD_HIGH  = 16'h005A;
  localparam logic [CHAR_W-1:0] FOLD_DELTA = 16'd32;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_ID,
    S_CHAR,
    S_RESOLVE,
    S_SHRD,
    S_SHWR,
    S_PUT,
    S_KEY
  } state_t;

  typedef struct packed {
    logic    load;
    logic    probe;
    logic    take_id;
    logic    next_char;
    logic    update;
    logic    sh_init;
    logic    sh_read;
    logic    sh_write;
    logic    put;
    logic    key_write;
    logic    finish;
    status_t fin_status;
  } ctl_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic cmp_done;
    logic at_rank;
    logic found;
    logic insert;
    logic full;
    logic key_last;
  } sts_t;

endpackage

FILE: hw/rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for search, index shift and key store.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    ctl        = '0;
    ctl.fin_status = ST_FOUND;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.lo_lt_hi) begin
          ctl.probe  = 1'b1;
          state_next = S_ID;
        end else begin
          state_next = S_RESOLVE;
        end
      end
      S_ID: begin
        ctl.take_id = 1'b1;
        state_next  = S_CHAR;
      end
      S_CHAR: begin
        if (sts.cmp_done) begin
          ctl.update = 1'b1;
          state_next = S_PROBE;
        end else begin
          ctl.next_char = 1'b1;
        end
      end
      S_RESOLVE: begin
        if (sts.found) begin
          ctl.finish = 1'b1;
          ctl.fin_status = ST_FOUND;
          state_next = S_IDLE;
        end else if (!sts.insert) begin
          ctl.finish = 1'b1;
          ctl.fin_status = ST_ABSENT;
          state_next = S_IDLE;
        end else if (sts.full) begin
          ctl.finish = 1'b1;
          ctl.fin_status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          ctl.sh_init = 1'b1;
          state_next  = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sts.at_rank) begin
          state_next = S_PUT;
        end else begin
          ctl.sh_read = 1'b1;
          state_next  = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.sh_write = 1'b1;
        state_next   = S_SHRD;
      end
      S_PUT: begin
        ctl.put    = 1'b1;
        state_next = S_KEY;
      end
      S_KEY: begin
        ctl.key_write = 1'b1;
        if (sts.key_last) begin
          ctl.finish = 1'b1;
          ctl.fin_status = ST_INSERTED;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp
// Query registers, key and index memories, search bounds and result beat.
// ----------------------------------------------------------------------------
module skt_dp import skt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic              command,
  input  logic [LEN_W-1:0]  key_length,
  input  logic [CHAR_W-1:0] chars_in [MAX_KEY_CHARS],
  output logic              done,
  output logic [IDX_W-1:0]  key_id,
  output logic [IDX_W-1:0]  sorted_rank,
  output logic [1:0]        status
);

  // memories
  logic [CHAR_W-1:0] key_mem [MAX_ENTRIES*MAX_KEY_CHARS];
  logic [LEN_W-1:0]  len_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]  ids_mem [MAX_ENTRIES];

  logic [CHAR_W-1:0] q [MAX_KEY_CHARS];
  logic [LEN_W-1:0]  qlen;
  logic              ins;
  logic [CNT_W-1:0]  count, lo, hi, mid, j;
  logic [IDX_W-1:0]  cur_id, fid, id_rd;
  logic [LEN_W-1:0]  slen;
  logic [CHAR_W-1:0] ch_rd;
  logic [CI_W-1:0]   ci;
  logic              found;

  logic [CNT_W-1:0]  mid_c;
  logic [LEN_W-1:0]  n_c;
  logic              at_end, ch_ne, lt_c, eq_c;
  logic [CHAR_W-1:0] qch;
  logic [CHAR_W-1:0] fold [MAX_KEY_CHARS];
  logic [CI_W-1:0]   ci_inc;

  // case folding of the incoming key
  always_comb begin
    for (int k = 0; k < MAX_KEY_CHARS; k++) begin
      if (chars_in[k] >= FOLD_LOW && chars_in[k] <= FOLD_HIGH)
        fold[k] = chars_in[k] + FOLD_DELTA;
      else
        fold[k] = chars_in[k];
    end
  end

  // probe compare
  assign mid_c  = lo + ((hi - lo) >> 1);
  assign n_c    = (slen < qlen) ? slen : qlen;
  assign at_end = ({{(LEN_W-CI_W+1){1'b0}}, ci} == {1'b0, n_c});
  assign qch    = q[ci[CHR_W-1:0]];
  assign ch_ne  = (ch_rd != qch);
  assign lt_c   = at_end ? (slen < qlen) : (ch_rd < qch);
  assign eq_c   = at_end && (slen == qlen);
  assign ci_inc = ci + 1'b1;

  assign sts.lo_lt_hi = (lo < hi);
  assign sts.cmp_done = at_end || ch_ne;
  assign sts.at_rank  = (j == lo);
  assign sts.found    = found;
  assign sts.insert   = (ins == CMD_INSERT);
  assign sts.full     = (count >= CNT_W'(MAX_ENTRIES));
  assign sts.key_last = (ci == CI_W'(MAX_KEY_CHARS - 1));

  // query capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int k = 0; k < MAX_KEY_CHARS; k++) q[k] <= fold[k];
      qlen <= (key_length > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS) : key_length;
      ins  <= command;
    end
  end

  // search bounds and walk pointers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo    <= '0;
      hi    <= count;
      found <= 1'b0;
    end
    if (ctl.probe) mid <= mid_c;
    if (ctl.take_id) begin
      cur_id <= id_rd;
      ci     <= '0;
    end
    if (ctl.next_char) ci <= ci_inc;
    if (ctl.update) begin
      if (lt_c) lo <= mid + 1'b1;
      else      hi <= mid;
      if (eq_c) begin
        found <= 1'b1;
        fid   <= cur_id;
      end
    end
    if (ctl.sh_init)  j <= count;
    if (ctl.sh_write) j <= j - 1'b1;
    if (ctl.put)      ci <= '0;
    if (ctl.key_write) ci <= ci_inc;
  end

  // sorted index memory
  always_ff @(posedge clk) begin
    if (ctl.sh_write) ids_mem[j[IDX_W-1:0]] <= id_rd;
    else if (ctl.put) ids_mem[lo[IDX_W-1:0]] <= count[IDX_W-1:0];
    if (ctl.probe)        id_rd <= ids_mem[mid_c[IDX_W-1:0]];
    else if (ctl.sh_read) id_rd <= ids_mem[IDX_W'(j - 1'b1)];
  end

  // key length memory
  always_ff @(posedge clk) begin
    if (ctl.put)     len_mem[count[IDX_W-1:0]] <= qlen;
    if (ctl.take_id) slen <= len_mem[id_rd];
  end

  // key character memory
  always_ff @(posedge clk) begin
    if (ctl.key_write)
      key_mem[{count[IDX_W-1:0], ci[CHR_W-1:0]}] <=
        ({{(LEN_W-CI_W+1){1'b0}}, ci} < {1'b0, qlen}) ? qch : '0;
    if (ctl.take_id)        ch_rd <= key_mem[{id_rd, {CHR_W{1'b0}}}];
    else if (ctl.next_char) ch_rd <= key_mem[{cur_id, ci_inc[CHR_W-1:0]}];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (ctl.finish && ctl.fin_status == ST_INSERTED) count <= count + 1'b1;
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctl.finish;
    if (ctl.finish) begin
      sorted_rank <= lo[IDX_W-1:0];
      status      <= ctl.fin_status;
      case (ctl.fin_status)
        ST_FOUND:    key_id <= fid;
        ST_INSERTED: key_id <= count[IDX_W-1:0];
        default:     key_id <= '0;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sorted_key_table_insert_find.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_find
// Key table with ids in arrival order and a sorted index searched by
// binary search; find or insert one key per command.
// ----------------------------------------------------------------------------
// channel  | handshake          | fields
// command  | start / busy       | command, key_length, char0..char7
// result   | done (one cycle)   | key_id, sorted_rank, status
//
// search: load the query, then per probe read the index, take the id and
// compare chars up to a difference or a key end, with probes up to
// ceil(log2(entries+1)); an insert then shifts each index slot from the rank up
// (one read, one write on the index memory port), then stores the id and key.
// the result beat is registered and shows in the cycle after the last work cycle; busy is low then.
// reset empties the table at once; memories need no clearing.
// the receiver takes every result beat; there is no stall.
module sorted_key_table_insert_find import skt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [3:0]  key_length,
  input  logic [15:0] char0,
  input  logic [15:0] char1,
  input  logic [15:0] char2,
  input  logic [15:0] char3,
  input  logic [15:0] char4,
  input  logic [15:0] char5,
  input  logic [15:0] char6,
  input  logic [15:0] char7,
  output logic        done,
  output logic [8:0]  key_id,
  output logic [8:0]  sorted_rank,
  output logic [1:0]  status
);

  ctl_t ctl;
  sts_t sts;
  logic [CHAR_W-1:0] chars_in [MAX_KEY_CHARS];

  assign chars_in[0] = char0;
  assign chars_in[1] = char1;
  assign chars_in[2] = char2;
  assign chars_in[3] = char3;
  assign chars_in[4] = char4;
  assign chars_in[5] = char5;
  assign chars_in[6] = char6;
  assign chars_in[7] = char7;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  skt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .key_length  (key_length),
    .chars_in    (chars_in),
    .done        (done),
    .key_id      (key_id),
    .sorted_rank (sorted_rank),
    .status      (status)
  );

endmodule

FILE: hw/rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on command and result beats of the key table.
// ----------------------------------------------------------------------------
module skt_checker import skt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [8:0] key_id,
  input logic [1:0] status
);

  // an accepted command beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after command");

  // a result beat follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");

  // result beats never come back to back
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("repeated result beat");

  // absent or full reports carry id zero
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_ABSENT || status == ST_FULL) |-> key_id == '0)
    else $error("nonzero id without key");

endmodule

bind sorted_key_table_insert_find skt_checker u_skt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .key_id (key_id),
  .status (status)
);

FILE: verif/sorted_key_table_insert_find_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_find_tb
// Drives find and insert commands into the sorted key table, predicts each
// result with a behavioral table model and compares every result beat.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_find_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  typedef struct {
    logic        cmd;
    logic [3:0]  len;
    logic [15:0] ch [8];
  } key_cmd_t;

  typedef struct {
    logic [8:0] id;
    logic [8:0] rank;
    status_t    st;
  } lookup_t;

  logic        clk, rst, start, busy, command, done;
  logic [3:0]  key_length;
  logic [15:0] char0, char1, char2, char3, char4, char5, char6, char7;
  logic [8:0]  key_id, sorted_rank;
  logic [1:0]  status;

  sorted_key_table_insert_find u_top (.*);

  // shadow table
  logic [15:0] tbl_chars [MAX_ENTRIES][MAX_KEY_CHARS];
  int unsigned tbl_len [MAX_ENTRIES];
  int unsigned tbl_order [MAX_ENTRIES];
  int unsigned tbl_count;

  key_cmd_t pending_cmds[$];
  lookup_t  expected_lookups[$];
  int       errors;
  int       send_idle_pct;
  int       sent, checked;
  logic [15:0] pool [$];
  logic     busy_at_rise;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // compare stored key of id with folded query
  function automatic int key_order(int unsigned id, logic [15:0] q[8], int unsigned ql);
    int unsigned n;
    n = tbl_len[id] < ql ? tbl_len[id] : ql;
    for (int i = 0; i < n; i++) begin
      if (tbl_chars[id][i] < q[i]) return -1;
      if (tbl_chars[id][i] > q[i]) return 1;
    end
    if (tbl_len[id] < ql) return -1;
    if (tbl_len[id] > ql) return 1;
    return 0;
  endfunction

  function automatic lookup_t predict_lookup(key_cmd_t c);
    logic [15:0] q [8];
    int unsigned ql, lo, hi, mid, id;
    lookup_t r;
    ql = c.len > MAX_KEY_CHARS ? MAX_KEY_CHARS : c.len;
    for (int i = 0; i < 8; i++) begin
      q[i] = (i < ql) ? c.ch[i] : 16'd0;
      if (q[i] >= FOLD_LOW && q[i] <= FOLD_HIGH) q[i] = q[i] + FOLD_DELTA;
    end
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (key_order(tbl_order[mid], q, ql) < 0) lo = mid + 1;
      else hi = mid;
    end
    r.rank = lo[8:0];
    if (lo < tbl_count && key_order(tbl_order[lo], q, ql) == 0) begin
      r.id = tbl_order[lo][8:0];
      r.st = ST_FOUND;
    end else if (c.cmd != CMD_INSERT) begin
      r.id = '0;
      r.st = ST_ABSENT;
    end else if (tbl_count >= MAX_ENTRIES) begin
      r.id = '0;
      r.st = ST_FULL;
    end else begin
      id = tbl_count;
      for (int k = tbl_count; k > lo; k--) tbl_order[k] = tbl_order[k-1];
      tbl_order[lo] = id;
      for (int i = 0; i < 8; i++) tbl_chars[id][i] = q[i];
      tbl_len[id] = ql;
      tbl_count++;
      r.id = id[8:0];
      r.st = ST_INSERTED;
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(16'h41, 16'h5A));
      2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return pool[$urandom_range(0, pool.size() - 1)];
    endcase
  endfunction

  function automatic key_cmd_t make_cmd(bit cmd, int len, logic [15:0] fill);
    key_cmd_t c;
    c.cmd = cmd;
    c.len = 4'(len);
    for (int i = 0; i < 8; i++) c.ch[i] = fill;
    return c;
  endfunction

  task automatic drive_next();
    key_cmd_t c;
    c = pending_cmds.pop_front();
    sent++;
    start <= 1;
    command <= c.cmd;
    key_length <= c.len;
    char0 <= c.ch[0]; char1 <= c.ch[1]; char2 <= c.ch[2]; char3 <= c.ch[3];
    char4 <= c.ch[4]; char5 <= c.ch[5]; char6 <= c.ch[6]; char7 <= c.ch[7];
  endtask

  // wait until every queued beat is sent and its result checked
  task automatic drain();
    while (pending_cmds.size() != 0 || checked != sent) @(negedge clk);
  endtask

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) busy_at_rise <= busy;

  // driver: start beats at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && !busy_at_rise) begin
      // beat was taken at the last rising edge
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) drive_next();
      else start <= 0;
    end else if (!start && pending_cmds.size() > 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      drive_next();
    end
  end

  // predict on each accepted command beat
  always @(posedge clk) begin
    key_cmd_t c;
    if (!rst && start && !busy) begin
      c.cmd = command;
      c.len = key_length;
      c.ch = '{char0, char1, char2, char3, char4, char5, char6, char7};
      expected_lookups.push_back(predict_lookup(c));
    end
  end

  // monitor: check result beats
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = expected_lookups.pop_front();
        checked++;
        if (key_id !== e.id)
          report($sformatf("key_id %0d, expected %0d", key_id, e.id));
        if (sorted_rank !== e.rank)
          report($sformatf("sorted_rank %0d, expected %0d", sorted_rank, e.rank));
        if (status !== e.st)
          report($sformatf("status %0d, expected %0d", status, e.st));
      end
    end
  end

  // stimulus
  initial begin
    key_cmd_t c;
    rst = 1; start = 0; command = 0; key_length = 0;
    char0 = 0; char1 = 0; char2 = 0; char3 = 0;
    char4 = 0; char5 = 0; char6 = 0; char7 = 0;
    errors = 0; tbl_count = 0; send_idle_pct = 35; sent = 0; checked = 0;
    for (int i = 0; i < 8; i++) pool.push_back(16'($urandom_range(16'h61, 16'h7A)));
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: empty-table find, empty key, length saturation, case folding
    pending_cmds.push_back(make_cmd(0, 3, 16'h61));
    pending_cmds.push_back(make_cmd(1, 0, 16'h00));
    pending_cmds.push_back(make_cmd(1, 0, 16'h55));
    pending_cmds.push_back(make_cmd(1, 15, 16'hFFFF));
    pending_cmds.push_back(make_cmd(0, 8, 16'hFFFF));
    pending_cmds.push_back(make_cmd(1, 9, 16'h0000));
    pending_cmds.push_back(make_cmd(1, 2, 16'h41));
    pending_cmds.push_back(make_cmd(0, 2, 16'h61));
    pending_cmds.push_back(make_cmd(1, 2, 16'h5A));
    pending_cmds.push_back(make_cmd(0, 2, 16'h7A));
    pending_cmds.push_back(make_cmd(1, 1, 16'h40));
    pending_cmds.push_back(make_cmd(1, 1, 16'h5B));
    pending_cmds.push_back(make_cmd(1, 3, 16'h0000));
    pending_cmds.push_back(make_cmd(0, 1, 16'h0000));
    pending_cmds.push_back(make_cmd(1, 4, 16'hAAAA));
    pending_cmds.push_back(make_cmd(1, 4, 16'h5555));
    pending_cmds.push_back(make_cmd(0, 4, 16'h5555));

    // random: fill the table past full, then mostly repeat keys
    for (int n = 0; n < 1000; n++) begin
      if (n == 330) begin
        drain();
        send_idle_pct = 67;
      end
      if (n == 660) begin
        drain();
        send_idle_pct = 0;
      end
      c.cmd = ($urandom_range(0, 99) < 75);
      c.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 4));
      for (int i = 0; i < 8; i++) c.ch[i] = pick_char();
      pending_cmds.push_back(c);
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_dp.sv
hw/rtl/sorted_key_table_insert_find.sv
hw/rtl/skt_checker.sv
verif/sorted_key_table_insert_find_tb.sv
